// ----- rtl/s3rp_pkg.sv -----
// Package for the SHA-256 three-round precompute block.
// Holds word types, round constants and the round function.
// No dependencies.
package s3rp_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 3;
  localparam int unsigned RoundIdxW = $clog2(Rounds);

  typedef logic [WordW-1:0] word_t;

  // Round constants K0 to K2
  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf
  };

  typedef struct packed {
    word_t mid_a;
    word_t mid_b;
    word_t mid_c;
    word_t mid_d;
    word_t mid_e;
    word_t mid_f;
    word_t mid_g;
    word_t mid_h;
    word_t msg_word0;
    word_t msg_word1;
    word_t msg_word2;
  } in_word_t;

  typedef struct packed {
    word_t out_a;
    word_t out_b;
    word_t out_c;
    word_t out_d;
    word_t out_e;
    word_t out_f;
    word_t out_g;
    word_t out_h;
  } out_word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } state_t;

  // Word handed from cell to cell: working state and the schedule words
  typedef struct packed {
    state_t               st;
    logic [Rounds-1:0][WordW-1:0] msg;
  } cell_word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(input word_t x, input word_t y, input word_t z);
    choose = (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(input word_t x, input word_t y, input word_t z);
    majority = (x & y) ^ (x & z) ^ (y & z);
  endfunction

  // One compression round; sums wrap at the word width
  function automatic state_t sha_round(input state_t s, input word_t k, input word_t w);
    word_t  t1;
    word_t  t2;
    state_t r;
    t1 = s.h + big_sigma1(s.e) + choose(s.e, s.f, s.g) + k + w;
    t2 = big_sigma0(s.a) + majority(s.a, s.b, s.c);
    r.h = s.g;
    r.g = s.f;
    r.f = s.e;
    r.e = s.d + t1;
    r.d = s.c;
    r.c = s.b;
    r.b = s.a;
    r.a = t1 + t2;
    sha_round = r;
  endfunction

endpackage

// ----- rtl/s3rp_if.sv -----
// Channel interfaces for the SHA-256 three-round precompute block.
// Depends on s3rp_pkg.
interface s3rp_in_if import s3rp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface s3rp_out_if import s3rp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sha256_three_round_precompute.sv -----
// Top level of the SHA-256 three-round precompute block.
// Depends on s3rp_pkg, s3rp_if and s3rp_round_cell.
//
// Takes a midstate (a to h) and three message words and returns the working
// variables after SHA-256 rounds 0, 1 and 2. Three round cells in a chain,
// each one register stage, do one round apiece, and one word is accepted
// every cycle while the output side takes results. Each cell drains into
// the next, so a stall at the output backs up through the chain without
// loss.
// No state is kept between words and there is nothing to configure.
module sha256_three_round_precompute
  import s3rp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  s3rp_in_if.sink    in_chan,
  s3rp_out_if.source out_chan
);

  logic       valid_c [Rounds+1];
  logic       ready_c [Rounds+1];
  cell_word_t word_c  [Rounds+1];

  // Unpack the input word into the chain format
  assign valid_c[0]        = in_chan.valid;
  assign in_chan.ready     = ready_c[0];
  assign word_c[0].st.a    = in_chan.data.mid_a;
  assign word_c[0].st.b    = in_chan.data.mid_b;
  assign word_c[0].st.c    = in_chan.data.mid_c;
  assign word_c[0].st.d    = in_chan.data.mid_d;
  assign word_c[0].st.e    = in_chan.data.mid_e;
  assign word_c[0].st.f    = in_chan.data.mid_f;
  assign word_c[0].st.g    = in_chan.data.mid_g;
  assign word_c[0].st.h    = in_chan.data.mid_h;
  assign word_c[0].msg[0]  = in_chan.data.msg_word0;
  assign word_c[0].msg[1]  = in_chan.data.msg_word1;
  assign word_c[0].msg[2]  = in_chan.data.msg_word2;

  // Chain of round cells
  for (genvar i = 0; i < Rounds; i++) begin : g_cell
    s3rp_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (RoundIdxW'(i)),
      .up_valid  (valid_c[i]),
      .up_ready  (ready_c[i]),
      .up_word   (word_c[i]),
      .dn_valid  (valid_c[i+1]),
      .dn_ready  (ready_c[i+1]),
      .dn_word   (word_c[i+1])
    );
  end

  // Drive the result word from the last cell
  assign out_chan.valid      = valid_c[Rounds];
  assign ready_c[Rounds]     = out_chan.ready;
  assign out_chan.data.out_a = word_c[Rounds].st.a;
  assign out_chan.data.out_b = word_c[Rounds].st.b;
  assign out_chan.data.out_c = word_c[Rounds].st.c;
  assign out_chan.data.out_d = word_c[Rounds].st.d;
  assign out_chan.data.out_e = word_c[Rounds].st.e;
  assign out_chan.data.out_f = word_c[Rounds].st.f;
  assign out_chan.data.out_g = word_c[Rounds].st.g;
  assign out_chan.data.out_h = word_c[Rounds].st.h;

endmodule

// ----- rtl/s3rp_round_cell.sv -----
// One round cell of the precompute chain: applies a single SHA-256 round
// and holds the result in a register. Depends on s3rp_pkg.
module s3rp_round_cell
  import s3rp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [RoundIdxW-1:0] round_idx,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  cell_word_t           up_word,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output cell_word_t           dn_word
);

  logic       valid_r;
  cell_word_t word_r;
  cell_word_t word_nxt;

  // Take a new word whenever the register is empty or being drained
  assign up_ready = !valid_r || dn_ready;

  // Apply this cell's round; schedule words pass on unchanged
  always_comb begin
    word_nxt     = up_word;
    word_nxt.st  = sha_round(up_word.st, RoundK[round_idx], up_word.msg[round_idx]);
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Load the payload on each accepted word
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule
